[design/tcw_pkg.sv]
// Package for the text console writer: item types, mode codes and character constants.
// No dependencies; used by the top level text_console_writer_core.
`timescale 1ns / 1ps

package tcw_pkg;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_BKSP  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
        logic [6:0]  column_now;
        logic [4:0]  row_now;
        logic [10:0] hw_cursor;
    } t_out_item;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] COLOR_RESET  = 8'd15;

endpackage

[design/tcw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies; the console cell store is an instance of it.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/text_console_writer_core.sv]
// Text console writer: character cell store with put char, backspace, clear and read.
// Each item passes through EXEC and then WRITE (put char, backspace), RDWAIT (on-screen read) or
// straight to DONE (plain newline, ignored backspace, off-screen read). One item in flight.
// A scroll copies the store up one row and fills the last row with blanks; clear fills every cell.
// After reset the store is swept to zero, all CELLS cells (2000 by default), with no item accepted.
// Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps

module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcw_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tcw_pkg::t_out_item o_out,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EXEC   = 8'b0000_0010,
        ST_WRITE  = 8'b0000_0100,
        ST_SCROLL = 8'b0000_1000,
        ST_FILL   = 8'b0001_0000,
        ST_INIT   = 8'b0010_0000,
        ST_RDWAIT = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] row, logic [CW-1:0] col);
        return AW'(32'(row) * 32'(COLUMNS) + 32'(col));
    endfunction

    t_state          r_state, n_state;
    logic [7:0]      r_color, n_color;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [10:0]     r_cursor, n_cursor;
    logic [PW-1:0]   r_ptr, n_ptr;
    logic            r_cp_vld, n_cp_vld;
    logic            r_pend, n_pend;
    logic            r_out_vld, n_out_vld;
    t_in_item        r_item, n_item;
    logic [15:0]     r_cell, n_cell;
    logic [AW-1:0]   r_cp_addr, n_cp_addr;
    t_out_item       r_out, n_out;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [15:0]     ram_wdata, ram_rdata;
    logic [15:0]     blank;
    logic            put;
    logic [CW-1:0]   col_inc;

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign blank      = {r_color, CHAR_SPACE};
    assign put        = (r_item.mode == MODE_PUT);
    assign col_inc    = r_col + CW'(1);
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out      = r_out;

    always_comb begin
        n_state   = r_state;
        n_color   = i_cfg_we ? i_cfg_data : r_color;
        n_col     = r_col;
        n_row     = r_row;
        n_cursor  = r_cursor;
        n_ptr     = r_ptr;
        n_cp_vld  = 1'b0;
        n_pend    = r_pend;
        n_item    = r_item;
        n_cell    = r_cell;
        n_cp_addr = AW'(32'(r_ptr) - 32'(COLUMNS));
        n_out     = r_out;
        n_out_vld = r_out_vld & ~i_out_ready;
        ram_we    = 1'b0;
        ram_waddr = cell_addr(r_row, r_col);
        ram_wdata = blank;
        ram_re    = 1'b0;
        ram_raddr = r_ptr[AW-1:0];

        // scroll copy writes back in the cycle after its read
        if (r_cp_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_addr;
            ram_wdata = ram_rdata;
        end

        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[AW-1:0];
                ram_wdata = '0;
                n_ptr     = r_ptr + PW'(1);
                if (r_ptr == PW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_cell = '0;
                n_pend = 1'b0;
                case (r_item.mode)
                    MODE_PUT: begin
                        if (r_item.char_code == CHAR_NEWLINE ||
                            32'(r_col) >= 32'(COLUMNS)) begin
                            n_col = '0;
                            if (32'(r_row) < 32'(ROWS - 1)) begin
                                n_row   = r_row + RW'(1);
                                n_state = (r_item.char_code == CHAR_NEWLINE) ?
                                          ST_DONE : ST_WRITE;
                            end else begin
                                n_pend  = (r_item.char_code != CHAR_NEWLINE);
                                n_ptr   = PW'(COLUMNS);
                                n_state = ST_SCROLL;
                            end
                        end else begin
                            n_state = ST_WRITE;
                        end
                    end
                    MODE_BKSP: begin
                        if (r_col == '0 && r_row == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            if (r_col == '0) begin
                                n_row = r_row - RW'(1);
                                n_col = CW'(COLUMNS - 1);
                            end else begin
                                n_col = r_col - CW'(1);
                            end
                            n_state = ST_WRITE;
                        end
                    end
                    MODE_CLEAR: begin
                        n_ptr   = '0;
                        n_state = ST_FILL;
                    end
                    MODE_READ: begin
                        if (32'(r_item.read_row) < 32'(ROWS) &&
                            32'(r_item.read_col) < 32'(COLUMNS)) begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(32'(r_item.read_row) * 32'(COLUMNS) +
                                            32'(r_item.read_col));
                            n_state   = ST_RDWAIT;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_WRITE: begin
                ram_we    = 1'b1;
                ram_wdata = put ? {r_color, r_item.char_code} : blank;
                if (put) begin
                    n_col = col_inc;
                end
                n_cursor = 11'(32'(r_row) * 32'(COLUMNS) + 32'(put ? col_inc : r_col));
                n_state  = ST_DONE;
            end
            ST_SCROLL: begin
                if (r_ptr == PW'(CELLS)) begin
                    n_ptr   = PW'(CELLS - COLUMNS);
                    n_state = ST_FILL;
                end else begin
                    ram_re   = 1'b1;
                    n_cp_vld = 1'b1;
                    n_ptr    = r_ptr + PW'(1);
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[AW-1:0];
                ram_wdata = blank;
                n_ptr     = r_ptr + PW'(1);
                if (r_ptr == PW'(CELLS - 1)) begin
                    n_state = r_pend ? ST_WRITE : ST_DONE;
                end
            end
            ST_RDWAIT: begin
                n_cell  = ram_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out.cell_char  = r_cell[7:0];
                    n_out.cell_color = r_cell[15:8];
                    n_out.column_now = 7'(r_col);
                    n_out.row_now    = 5'(r_row);
                    n_out.hw_cursor  = r_cursor;
                    n_out_vld        = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_color   <= COLOR_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_cursor  <= '0;
            r_ptr     <= '0;
            r_cp_vld  <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_color   <= n_color;
            r_col     <= n_col;
            r_row     <= n_row;
            r_cursor  <= n_cursor;
            r_ptr     <= n_ptr;
            r_cp_vld  <= n_cp_vld;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_cell    <= n_cell;
        r_cp_addr <= n_cp_addr;
        r_out     <= n_out;
    end

endmodule

[tb/tcw_checker.sv]
// Scoreboard for text_console_writer_core: keeps its own copy of the cell store, write
// position, cursor and color, predicts each result and compares it with the output channel.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  tcw_pkg::t_in_item i_in,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  tcw_pkg::t_out_item i_out,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_scroll_count
);

    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    logic [15:0] screen [CELLS];
    int          cur_col;
    int          cur_row;
    logic [10:0] cursor;
    logic [7:0]  color;
    int          fails;
    int          scrolls;
    t_out_item   pending_results [$];

    function automatic logic [10:0] cursor_here();
        return 11'(cur_row * COLUMNS + cur_col);
    endfunction

    // Newline: column to 0, next row or scroll the whole store up one row.
    task automatic line_feed();
        cur_col = 0;
        if (cur_row < ROWS - 1) begin
            cur_row++;
        end else begin
            for (int i = COLUMNS; i < CELLS; i++)
                screen[i - COLUMNS] = screen[i];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = {color, CHAR_SPACE};
            scrolls++;
        end
    endtask

    task automatic console_apply(input t_in_item it, output t_out_item res);
        res = '0;
        case (it.mode)
            MODE_PUT: begin
                if (it.char_code == CHAR_NEWLINE) begin
                    // cursor stays where it was
                    line_feed();
                end else begin
                    if (cur_col >= COLUMNS)
                        line_feed();
                    screen[cur_row * COLUMNS + cur_col] = {color, it.char_code};
                    cur_col++;
                    cursor = cursor_here();
                end
            end
            MODE_BKSP: begin
                // ignored at top-left; at column 0 steps to the end of the row above
                if (!(cur_col == 0 && cur_row == 0)) begin
                    if (cur_col == 0) begin
                        cur_row--;
                        cur_col = COLUMNS - 1;
                    end else begin
                        cur_col--;
                    end
                    screen[cur_row * COLUMNS + cur_col] = {color, CHAR_SPACE};
                    cursor = cursor_here();
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = {color, CHAR_SPACE};
            end
            MODE_READ: begin
                if (it.read_row < ROWS && it.read_col < COLUMNS)
                    {res.cell_color, res.cell_char} =
                        screen[int'(it.read_row) * COLUMNS + int'(it.read_col)];
            end
            default: ;
        endcase
        res.column_now = 7'(cur_col);
        res.row_now    = 5'(cur_row);
        res.hw_cursor  = cursor;
    endtask

    function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_out_item predicted;
        t_out_item oldest;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = '0;
            cur_col = 0;
            cur_row = 0;
            cursor  = '0;
            color   = COLOR_RESET;
            fails   = 0;
            scrolls = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_we)
                color = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                console_apply(i_in, predicted);
                pending_results.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: %p", i_out);
                    fails++;
                end else begin
                    oldest = pending_results.pop_front();
                    fails += field_differs("cell_char", oldest.cell_char, i_out.cell_char);
                    fails += field_differs("cell_color", oldest.cell_color, i_out.cell_color);
                    fails += field_differs("column_now", oldest.column_now, i_out.column_now);
                    fails += field_differs("row_now", oldest.row_now, i_out.row_now);
                    fails += field_differs("hw_cursor", oldest.hw_cursor, i_out.hw_cursor);
                end
            end
        end
        o_pending      <= pending_results.size();
        o_fail_count   <= fails;
        o_scroll_count <= scrolls;
    end

endmodule

[tb/tb.sv]
// Testbench top for text_console_writer_core: clock, reset, item stimulus, output stalls,
// color register writes, watchdog and verdict. Depends on tcw_pkg, tcw_checker and text_console_writer_core.
`timescale 1ns / 1ps

module tb;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 350;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    int fail_count;
    int pending;
    int scroll_count;

    // shared knobs: no idling on either side, and requests for a long output stall
    logic steady;
    int   hold_requests;

    int n_put, n_newline, n_bksp, n_clear, n_read, n_cfg;
    int idle_cycles = 0;

    text_console_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    tcw_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out         (o_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_scroll_count(scroll_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output side: random stalls, plus one long hold-off per request
    initial begin
        int hold_seen;
        hold_seen   = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= steady || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_in_item cmd(t_mode m, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
        t_in_item it;
        it.mode      = m;
        it.char_code = ch;
        it.read_row  = rr;
        it.read_col  = rc;
        return it;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       pick;
        pick         = $urandom_range(0, 99);
        it.char_code = 8'($urandom);
        it.read_row  = 5'($urandom);
        it.read_col  = 7'($urandom);
        if (pick < 60) begin
            it.mode = MODE_PUT;
            if ($urandom_range(0, 99) < 12)
                it.char_code = CHAR_NEWLINE;
        end else if (pick < 75) begin
            it.mode = MODE_BKSP;
        end else if (pick < 77) begin
            it.mode = MODE_CLEAR;
        end else begin
            it.mode = MODE_READ;
            // mostly cells on screen, the rest anywhere in the field range
            if ($urandom_range(0, 99) < 85) begin
                it.read_row = 5'($urandom_range(0, ROWS - 1));
                it.read_col = 7'($urandom_range(0, COLUMNS - 1));
            end
        end
        return it;
    endfunction

    // Offer one item and return at the edge where it is accepted; valid stays high.
    task automatic send(input t_in_item it);
        if (!steady && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        case (it.mode)
            MODE_PUT:   if (it.char_code == CHAR_NEWLINE) n_newline++; else n_put++;
            MODE_BKSP:  n_bksp++;
            MODE_CLEAR: n_clear++;
            MODE_READ:  n_read++;
            default:    ;
        endcase
    endtask

    // Stop offering and wait until every expected result has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        n_cfg++;
    endtask

    initial begin
        t_in_item   directed [$];
        logic [7:0] phase_color [PHASES];

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in          <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        steady        <= 1'b0;
        hold_requests <= 0;
        n_put = 0; n_newline = 0; n_bksp = 0; n_clear = 0; n_read = 0; n_cfg = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items run with the reset color
        directed.push_back(cmd(MODE_READ,  8'h00, 5'd0,  7'd0));
        directed.push_back(cmd(MODE_READ,  8'hFF, 5'd31, 7'd127));   // far out of range
        directed.push_back(cmd(MODE_BKSP,  8'h00, 5'd0,  7'd0));     // top-left: ignored
        directed.push_back(cmd(MODE_PUT,   8'h41, 5'd0,  7'd0));
        directed.push_back(cmd(MODE_PUT,   8'hFF, 5'd31, 7'd127));
        directed.push_back(cmd(MODE_PUT,   8'h00, 5'd0,  7'd0));
        directed.push_back(cmd(MODE_READ,  8'h00, 5'd0,  7'd1));
        directed.push_back(cmd(MODE_BKSP,  8'hFF, 5'd0,  7'd0));
        directed.push_back(cmd(MODE_READ,  8'h00, 5'd0,  7'd2));
        directed.push_back(cmd(MODE_PUT,   CHAR_NEWLINE, 5'd0, 7'd0));
        directed.push_back(cmd(MODE_BKSP,  8'h00, 5'd0,  7'd0));     // column 0 -> end of row above
        directed.push_back(cmd(MODE_PUT,   8'h78, 5'd0,  7'd0));     // column rests past the end
        directed.push_back(cmd(MODE_PUT,   8'h79, 5'd0,  7'd0));     // wraps first
        directed.push_back(cmd(MODE_READ,  8'h00, 5'd0,  7'd79));
        directed.push_back(cmd(MODE_READ,  8'h00, 5'd1,  7'd0));
        directed.push_back(cmd(MODE_READ,  8'h00, 5'd24, 7'd79));
        directed.push_back(cmd(MODE_READ,  8'h00, 5'd25, 7'd0));
        directed.push_back(cmd(MODE_READ,  8'h00, 5'd0,  7'd80));
        directed.push_back(cmd(MODE_CLEAR, 8'h00, 5'd0,  7'd0));
        directed.push_back(cmd(MODE_READ,  8'h00, 5'd1,  7'd0));
        directed.push_back(cmd(MODE_BKSP,  8'h00, 5'd0,  7'd0));
        directed.push_back(cmd(MODE_PUT,   CHAR_NEWLINE, 5'd0, 7'd0));
        foreach (directed[i])
            send(directed[i]);

        phase_color[0] = 8'h00;
        phase_color[1] = 8'hFF;
        for (int p = 2; p < PHASES; p++)
            phase_color[p] = 8'($urandom_range(0, 255));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_color(phase_color[p]);
            steady <= (p == 2);
            if (p == 3)
                hold_requests <= hold_requests + 1;
            repeat (PHASE_ITEMS)
                send(rand_item());
        end
        drain();

        $display("Covered %0d items: %0d chars, %0d newlines, %0d backspaces, %0d clears, %0d reads",
                 n_put + n_newline + n_bksp + n_clear + n_read,
                 n_put, n_newline, n_bksp, n_clear, n_read);
        $display("Color writes: %0d, scrolls seen: %0d, one long output stall",
                 n_cfg, scroll_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer_core.sv
tb/tcw_checker.sv
tb/tb.sv
